// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the executor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define SME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication
`define SME_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sme_pkg.sv =====
// types, constants and codes shared by the stack machine executor
package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int WORD_W      = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    localparam int OP_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 9;

    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 5;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 1;
    localparam int M_USED_W    = STATUS_W + WORD_W + DEPTH_W + WORD_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_EMIT  = 4'd6,
        OP_HALT  = 4'd7,
        OP_DUP   = 4'd8,
        OP_SWAP  = 4'd9
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_HALTED    = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_DIVZERO   = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic rd_en;
        logic alu_ld;
        logic div_start;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/stack_machine_executor.sv =====
// top level of the stack machine executor
//
// Executes one stack-machine instruction per input item on a stack of
// STACK_DEPTH 32-bit words and returns exactly one result item for it.
// Input channel s_*: s_tuser carries the opcode and the new_program flag,
// s_tdata the signed immediate used by push. new_program empties the stack
// and clears the stopped condition before the instruction runs.
// Result channel m_*: status, stack depth, top of stack and the printed word,
// with m_tuser flagging a print that found a non-empty stack.
// Timing: an item is taken in the idle state, the stack ram is read in the
// read state, the alu works in the execute state and the result is
// registered in the commit state; a divide that runs adds a divide state
// that waits for the one-bit-per-cycle divider before the commit.
// The next item is taken in the cycle after the result is registered, while
// the result may still wait in the output register. If the receiver stalls
// with a result still pending, the following item waits at its commit step.
// Reset (aresetn low, synchronous) empties the stack, clears the stopped
// condition and drops m_tvalid; the stack ram needs no clearing pass.
module stack_machine_executor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sme_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] immediate
    input  logic [sme_pkg::S_TUSER_W-1:0] s_tuser,  // [3:0] operation, [4] new_program
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [34:3] print_value, [43:35] stack_depth, [75:44] top_value
    output logic [sme_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sme_pkg::M_TUSER_W-1:0] m_tuser   // [0] print_valid
);
    import sme_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sme_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

// ===== rtl/core/sme_ram.sv =====
// generic single-write, single-read ram with registered read data
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sme_div.sv =====
// iterative signed truncating divider, one quotient bit per cycle
module sme_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sme_pkg::WORD_W-1:0] dividend,
    input  logic [sme_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [sme_pkg::WORD_W-1:0] quotient
);
    import sme_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    dsr_reg, dsr_next;
    logic                 neg_reg, neg_next;

    logic [WORD_W:0]      rem_sh;
    logic [WORD_W:0]      trial;
    logic [WORD_W-1:0]    dvd_mag;
    logic [WORD_W-1:0]    dsr_mag;

    always_comb begin
        dvd_mag = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
        dsr_mag = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
        rem_sh  = {rem_reg, quo_reg[WORD_W-1]};
        trial   = rem_sh - {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;

        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dvd_mag;
            dsr_next  = dsr_mag;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end else if (busy_reg) begin
            // restoring step: keep the difference when it does not go negative
            if (!trial[WORD_W]) begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== rtl/core/sme_ctrl.sv =====
// instruction sequencer: accept, stack read, execute, divide wait, commit
`include "assert_macros.svh"

module sme_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output sme_pkg::cmd_t cmd,
    input  sme_pkg::sts_t sts
);
    import sme_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.alu_ld = 1'b1;
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SME_ASSERT(a_one_step, $onehot0({cmd.latch, cmd.rd_en, cmd.alu_ld, cmd.commit}), "overlapping commands")
    `SME_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, cmd.rd_en, "accepted item not read")
    `SME_ASSERT_NEXT(a_read_execs, cmd.rd_en, cmd.alu_ld && !s_tready, "read not followed by execute")

endmodule

// ===== rtl/core/sme_datapath.sv =====
// stack datapath: top-of-stack register, stack ram below it, alu, divider, result register
`include "assert_macros.svh"

module sme_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sme_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [sme_pkg::S_TUSER_W-1:0] s_tuser,
    input  sme_pkg::cmd_t                 cmd,
    output sme_pkg::sts_t                 sts,
    output logic [sme_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sme_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import sme_pkg::*;

    opcode_t                op_reg;
    logic [WORD_W-1:0]      imm_reg;
    logic                   newp_reg;
    logic [SP_W-1:0]        sp_reg;
    logic                   stopped_reg;
    logic [WORD_W-1:0]      top_reg;
    logic [WORD_W-1:0]      alu_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;
    logic                   m_tvalid_reg;

    logic [SP_W-1:0]        eff_sp;
    logic                   eff_stopped;
    logic [SP_W-1:0]        sp_m1;
    logic [SP_W-1:0]        sp_m2;
    logic [SP_W-1:0]        sp_p1;
    logic                   empty;
    logic                   full;
    logic                   two;
    logic [WORD_W-1:0]      second;
    logic [WORD_W-1:0]      quotient;
    logic                   div_done;
    logic [WORD_W-1:0]      alu_c;

    status_t                st_c;
    logic                   pvalid_c;
    logic [WORD_W-1:0]      pvalue_c;
    logic [SP_W-1:0]        sp_c;
    logic [WORD_W-1:0]      top_c;
    logic                   we_c;
    logic [ADDR_W-1:0]      waddr_c;
    logic [WORD_W-1:0]      wdata_c;
    logic [WORD_W-1:0]      top_out;
    logic [M_USED_W-1:0]    out_pack;

    // new_program takes effect before the instruction itself
    assign eff_sp      = newp_reg ? '0 : sp_reg;
    assign eff_stopped = newp_reg ? 1'b0 : stopped_reg;
    assign sp_m1       = eff_sp - 1'b1;
    assign sp_m2       = eff_sp - SP_W'(2);
    assign sp_p1       = eff_sp + 1'b1;
    assign empty       = (eff_sp == '0);
    assign full        = (eff_sp >= SP_W'(STACK_DEPTH));
    assign two         = (eff_sp >= SP_W'(2));

    // entries below the top live in the ram at their own index
    sme_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (cmd.commit && we_c),
        .wr_addr (waddr_c),
        .wr_data (wdata_c),
        .rd_en   (cmd.rd_en),
        .rd_addr (sp_m2[ADDR_W-1:0]),
        .rd_data (second)
    );

    sme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (second),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        unique case (op_reg)
            OP_ADD:  alu_c = second + top_reg;
            OP_SUB:  alu_c = second - top_reg;
            default: alu_c = second * top_reg;
        endcase
    end

    always_comb begin
        sts.need_div = !eff_stopped && (op_reg == OP_DIV) && two && (top_reg != '0);
        sts.div_done = div_done;
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        st_c     = ST_OK;
        pvalid_c = 1'b0;
        pvalue_c = '0;
        sp_c     = eff_sp;
        top_c    = top_reg;
        we_c     = 1'b0;
        waddr_c  = sp_m1[ADDR_W-1:0];
        wdata_c  = top_reg;
        if (eff_stopped) begin
            st_c = ST_IGNORED;
        end else begin
            unique case (op_reg)
                OP_PUSH: begin
                    if (full) begin
                        st_c = ST_OVERFLOW;
                    end else begin
                        // old top drops into the ram
                        we_c  = !empty;
                        top_c = imm_reg;
                        sp_c  = sp_p1;
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        st_c = ST_UNDERFLOW;
                    end else begin
                        top_c = second;
                        sp_c  = sp_m1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (!two) begin
                        st_c = ST_UNDERFLOW;
                    end else if ((op_reg == OP_DIV) && (top_reg == '0)) begin
                        st_c = ST_DIVZERO;
                    end else begin
                        top_c = (op_reg == OP_DIV) ? quotient : alu_reg;
                        sp_c  = sp_m1;
                    end
                end
                OP_EMIT: begin
                    if (!empty) begin
                        pvalid_c = 1'b1;
                        pvalue_c = top_reg;
                    end
                end
                OP_HALT: begin
                    st_c = ST_HALTED;
                end
                OP_DUP: begin
                    if (!empty) begin
                        if (full) begin
                            st_c = ST_OVERFLOW;
                        end else begin
                            we_c = 1'b1;
                            sp_c = sp_p1;
                        end
                    end
                end
                OP_SWAP: begin
                    if (two) begin
                        we_c    = 1'b1;
                        waddr_c = sp_m2[ADDR_W-1:0];
                        top_c   = second;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign top_out  = (sp_c != '0) ? top_c : '0;
    assign out_pack = {top_out, DEPTH_W'(sp_c), pvalue_c, st_c};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg       <= '0;
            stopped_reg  <= 1'b0;
            newp_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.latch) begin
                newp_reg <= s_tuser[OP_W];
            end
            if (cmd.commit) begin
                sp_reg       <= sp_c;
                stopped_reg  <= eff_stopped || (st_c != ST_OK);
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= opcode_t'(s_tuser[OP_W-1:0]);
            imm_reg <= s_tdata[WORD_W-1:0];
        end
        if (cmd.alu_ld) begin
            alu_reg <= alu_c;
        end
        if (cmd.commit) begin
            top_reg     <= top_c;
            m_tdata_reg <= M_TDATA_W'(out_pack);
            m_tuser_reg <= M_TUSER_W'(pvalid_c);
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    `SME_ASSERT(a_sp_range, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
    `SME_ASSERT_IMPL(a_commit_room, cmd.commit, !m_tvalid_reg || m_tready, "result overwritten")
    `SME_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid_reg, "committed item not presented")
    `SME_ASSERT_NEXT(a_ignored_holds, cmd.commit && eff_stopped, $stable(sp_reg) && $stable(top_reg) && stopped_reg, "stopped stack changed")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the stack machine executor
module testbench;
    import sme_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 60;

    // opcodes outside the defined set act as no-ops
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd10;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] imm;
        logic              new_prog;
    } instr_t;

    typedef struct packed {
        status_t            status;
        logic               print_valid;
        logic [WORD_W-1:0]  print_value;
        logic [DEPTH_W-1:0] depth;
        logic [WORD_W-1:0]  top;
    } outcome_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [31:0] immediate
    logic [S_TUSER_W-1:0] s_tuser = '0;   // [3:0] operation, [4] new_program
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [2:0] status, [34:3] print_value, [43:35] stack_depth, [75:44] top_value
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;        // [0] print_valid

    // shadow machine state used for prediction
    logic [WORD_W-1:0] exec_stack [STACK_DEPTH];
    int unsigned       exec_depth = 0;
    bit                exec_stopped = 1'b0;

    instr_t   instr_q[$];
    outcome_t expected_q[$];
    instr_t   shown;
    int       send_gap = 0;
    int       result_stall = 0;
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;
    int       idle_cycles = 0;
    int       error_count = 0;

    // rough depth tracking used only to shape the stimulus
    int unsigned plan_depth = 0;
    bit          plan_stopped = 1'b0;
    int          live_count = 0;

    stack_machine_executor dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [WORD_W-1:0] alu_word(input logic [OP_W-1:0] op,
                                                  input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        longint sa;
        longint sb;
        longint q;
        sa = {{32{a[WORD_W-1]}}, a};
        sb = {{32{b[WORD_W-1]}}, b};
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            default: begin
                // 64-bit quotient, so min / -1 simply wraps back to min
                q = sa / sb;
                return q[WORD_W-1:0];
            end
        endcase
    endfunction

    function automatic outcome_t execute_instr(input instr_t it);
        outcome_t    res;
        int unsigned sp;
        logic [WORD_W-1:0] held;
        res.status      = ST_OK;
        res.print_valid = 1'b0;
        res.print_value = '0;
        if (it.new_prog) begin
            exec_depth   = 0;
            exec_stopped = 1'b0;
        end
        sp = exec_depth;
        if (exec_stopped) begin
            res.status = ST_IGNORED;
        end else begin
            case (it.op)
                OP_PUSH: begin
                    if (sp >= STACK_DEPTH) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        exec_stack[sp] = it.imm;
                        sp++;
                    end
                end
                OP_POP: begin
                    if (sp == 0) res.status = ST_UNDERFLOW;
                    else sp--;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (sp < 2) begin
                        res.status = ST_UNDERFLOW;
                    end else if (it.op == OP_DIV && exec_stack[sp-1] == '0) begin
                        res.status = ST_DIVZERO;
                    end else begin
                        exec_stack[sp-2] = alu_word(it.op, exec_stack[sp-2], exec_stack[sp-1]);
                        sp--;
                    end
                end
                OP_EMIT: begin
                    if (sp > 0) begin
                        res.print_valid = 1'b1;
                        res.print_value = exec_stack[sp-1];
                    end
                end
                OP_HALT: res.status = ST_HALTED;
                OP_DUP: begin
                    if (sp > 0) begin
                        if (sp >= STACK_DEPTH) begin
                            res.status = ST_OVERFLOW;
                        end else begin
                            exec_stack[sp] = exec_stack[sp-1];
                            sp++;
                        end
                    end
                end
                OP_SWAP: begin
                    if (sp >= 2) begin
                        held             = exec_stack[sp-1];
                        exec_stack[sp-1] = exec_stack[sp-2];
                        exec_stack[sp-2] = held;
                    end
                end
                default: ;
            endcase
            if (res.status != ST_OK) exec_stopped = 1'b1;
        end
        exec_depth = sp;
        res.depth  = sp[DEPTH_W-1:0];
        res.top    = (sp > 0) ? exec_stack[sp-1] : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ns: %s", $realtime, msg);
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 45);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 16) - 8;
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic add_instr(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm,
                             input bit np);
        instr_t it;
        it.op       = op;
        it.imm      = imm;
        it.new_prog = np;
        instr_q.push_back(it);
        if (np) begin
            plan_depth   = 0;
            plan_stopped = 1'b0;
        end
        if (!plan_stopped) begin
            live_count++;
            case (op)
                OP_PUSH: begin
                    if (plan_depth >= STACK_DEPTH) plan_stopped = 1'b1;
                    else plan_depth++;
                end
                OP_POP: begin
                    if (plan_depth == 0) plan_stopped = 1'b1;
                    else plan_depth--;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (plan_depth < 2) plan_stopped = 1'b1;
                    else plan_depth--;
                end
                OP_HALT: plan_stopped = 1'b1;
                OP_DUP: begin
                    if (plan_depth >= STACK_DEPTH) plan_stopped = 1'b1;
                    else if (plan_depth > 0) plan_depth++;
                end
                default: ;
            endcase
        end
    endtask

    // fill to the limit, work at full depth, then overflow
    task automatic fill_stack_program();
        add_instr(OP_PUSH, pick_word(), 1'b1);
        while (plan_depth < STACK_DEPTH)
            add_instr(($urandom_range(0, 3) == 0) ? OP_DUP : OP_PUSH, pick_word(), 1'b0);
        add_instr(OP_EMIT, pick_word(), 1'b0);
        add_instr(OP_SWAP, pick_word(), 1'b0);
        add_instr(OP_POP, pick_word(), 1'b0);
        add_instr(OP_PUSH, pick_word(), 1'b0);
        add_instr(($urandom_range(0, 1) == 0) ? OP_DUP : OP_PUSH, pick_word(), 1'b0);
        add_instr(4'($urandom_range(0, 15)), pick_word(), 1'b0);
    endtask

    task automatic random_program();
        int len;
        int tail;
        int r;
        logic [OP_W-1:0] op;
        len  = $urandom_range(3, 40);
        tail = $urandom_range(0, 2);
        add_instr(($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : OP_PUSH,
                  pick_word(), 1'b1);
        while (len > 0 && !(plan_stopped && tail == 0)) begin
            if (plan_stopped) tail--;
            len--;
            r = $urandom_range(0, 99);
            if (r < 30)      op = OP_PUSH;
            else if (r < 37) op = OP_DUP;
            else if (r < 44) op = OP_POP;
            else if (r < 52) op = OP_ADD;
            else if (r < 58) op = OP_SUB;
            else if (r < 64) op = OP_MUL;
            else if (r < 72) op = OP_DIV;
            else if (r < 80) op = OP_EMIT;
            else if (r < 88) op = OP_SWAP;
            else if (r < 90) op = OP_HALT;
            else if (r < 92) op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            else             op = OP_PUSH;
            // keep most programs from underflowing right away
            if (plan_depth < 2 && op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POP} &&
                $urandom_range(0, 9) != 0)
                op = OP_PUSH;
            add_instr(op, pick_word(), $urandom_range(0, 49) == 0);
        end
        if (!plan_stopped && $urandom_range(0, 3) == 0) add_instr(OP_HALT, pick_word(), 1'b0);
    endtask

    task automatic noise_program();
        repeat ($urandom_range(2, 10))
            add_instr(4'($urandom_range(0, 15)), pick_word(), $urandom_range(0, 3) == 0);
    endtask

    always @(posedge aclk) begin : instr_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_q.push_back(execute_instr(shown));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (instr_q.size() > 0) begin
                    shown = instr_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= shown.imm;
                    s_tuser  <= {shown.new_prog, shown.op};
                    send_gap = pick_gap(tx_calm);
                    if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        outcome_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: tdata %h", m_tdata));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tdata[2:0], want.status));
                    if (m_tuser[0] !== want.print_valid)
                        report_mismatch($sformatf("print_valid %b, expected %b",
                                                  m_tuser[0], want.print_valid));
                    if (m_tdata[34:3] !== want.print_value)
                        report_mismatch($sformatf("print_value %h, expected %h",
                                                  m_tdata[34:3], want.print_value));
                    if (m_tdata[43:35] !== want.depth)
                        report_mismatch($sformatf("stack_depth %0d, expected %0d",
                                                  m_tdata[43:35], want.depth));
                    if (m_tdata[75:44] !== want.top)
                        report_mismatch($sformatf("top_value %h, expected %h",
                                                  m_tdata[75:44], want.top));
                    if (m_tdata[M_TDATA_W-1:76] !== '0)
                        report_mismatch($sformatf("tdata padding %h not zero",
                                                  m_tdata[M_TDATA_W-1:76]));
                end
                result_stall = pick_gap(rx_calm);
                if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
            end
            if (result_stall > 0) begin
                result_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        // directed: wrap, min / -1, truncation, stops and their recovery
        add_instr(OP_PUSH, 32'h7fff_ffff, 1'b1);
        add_instr(OP_PUSH, 32'h0000_0001, 1'b0);
        add_instr(OP_ADD, '0, 1'b0);
        add_instr(OP_PUSH, 32'hffff_ffff, 1'b0);
        add_instr(OP_DIV, '1, 1'b0);
        add_instr(OP_EMIT, '0, 1'b0);
        add_instr(OP_DUP, '0, 1'b0);
        add_instr(OP_MUL, '0, 1'b0);
        add_instr(OP_PUSH, 32'd7, 1'b0);
        add_instr(OP_PUSH, 32'hffff_fffe, 1'b0);
        add_instr(OP_DIV, '0, 1'b0);
        add_instr(OP_SUB, '0, 1'b0);
        add_instr(OP_SWAP, '0, 1'b0);
        add_instr(OP_PUSH, '0, 1'b0);
        add_instr(OP_SWAP, '0, 1'b0);
        add_instr(OP_DIV, '0, 1'b0);
        add_instr(OP_PUSH, '0, 1'b0);
        add_instr(OP_DIV, '0, 1'b0);
        add_instr(OP_PUSH, 32'd5, 1'b0);
        add_instr(OP_POP, '0, 1'b1);
        add_instr(OP_DUP, '0, 1'b1);
        add_instr(OP_EMIT, '0, 1'b0);
        add_instr(OP_FIRST_UNUSED, '0, 1'b0);
        add_instr(OP_LAST_UNUSED, '1, 1'b0);
        add_instr(OP_HALT, '0, 1'b0);
        add_instr(OP_SUB, '0, 1'b1);

        live_count = 0;
        fill_stack_program();
        while (live_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 49))
                0:             fill_stack_program();
                1, 2, 3, 4, 5: noise_program();
                default:       random_program();
            endcase
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // sample away from the active edge
        do @(negedge aclk);
        while (instr_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
